// ===== src/gregorian_date_difference_macros.svh =====
`ifndef GREGORIAN_DATE_DIFFERENCE_MACROS_SVH
`define GREGORIAN_DATE_DIFFERENCE_MACROS_SVH

// same-cycle implication, held off during reset
`define GDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define GDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gdd_pkg.sv =====
package gdd_pkg;

  localparam int unsigned MAX_YEAR = 9999;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DIFF_W  = 23;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 24;

  // day-number width: (2**YEAR_W) years of at most 366 days fit in 23 bits
  localparam int unsigned DN_W = 23;

  // p / 100 as (p * 5243) >> 19, exact for p below 2**14
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int unsigned Q100_W = 8;
  localparam int unsigned REM_W  = 7;

  localparam logic [8:0]         DAYS_PER_YEAR = 9'd365;
  localparam logic [6:0]         CENTURY       = 7'd100;
  localparam logic [REM_W-1:0]   CENTURY_LAST  = 7'd99;
  localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;

  localparam int DIFF_MAX = 4194303;
  localparam int DIFF_MIN = -4194304;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } gdd_en_t;

  // days before the first of the month in a common year
  function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
    logic [8:0] v;
    case (m)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/gregorian_date_difference.sv =====
// throughput: one date pair per cycle; each stage stalls only when the one after it is full
// stages: clamp and divide by 100, year and month days, day number, difference
// reset (synchronous, rst_n low) clears the stage valid bits; data registers are not reset
`include "gregorian_date_difference_macros.svh"

module gregorian_date_difference (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // first_day, first_month, first_year, second_day, second_month, second_year, zero pad
  input  logic [gdd_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // day_difference, zero pad
  output logic [gdd_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import gdd_pkg::*;

  logic    v1_r, v2_r, v3_r, v4_r;
  logic    en4;
  gdd_en_t en;

  // a stage moves when it is empty or the next one moves
  always_comb begin
    en4   = !v4_r || out_tready;
    en.s3 = !v3_r || en4;
    en.s2 = !v2_r || en.s3;
    en.s1 = !v1_r || en.s2;
  end

  assign in_tready = en.s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_tvalid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en4)   v4_r <= v3_r;
    end
  end

  logic [DN_W-1:0] first_num, second_num;

  gdd_day_number u_first (
    .clk     (clk),
    .en      (en),
    .day     (in_tdata[4:0]),
    .month   (in_tdata[8:5]),
    .year    (in_tdata[22:9]),
    .day_num (first_num)
  );

  gdd_day_number u_second (
    .clk     (clk),
    .en      (en),
    .day     (in_tdata[27:23]),
    .month   (in_tdata[31:28]),
    .year    (in_tdata[45:32]),
    .day_num (second_num)
  );

  logic signed [DIFF_W-1:0] day_difference;

  gdd_diff u_diff (
    .clk            (clk),
    .en             (en4),
    .first_num      (first_num),
    .second_num     (second_num),
    .day_difference (day_difference)
  );

  assign out_tvalid = v4_r;
  assign out_tdata  = {{(OUT_DATA_W-DIFF_W){1'b0}}, day_difference};

  // input side only stalls with every stage full and the output held
  `GDD_ASSERT_NOW(a_stall_full, !in_tready, v1_r && v2_r && v3_r && out_tvalid && !out_tready, "input stalled while pipeline has room")
  // a new result only appears from a valid third stage
  `GDD_ASSERT_NOW(a_rise_src, $rose(out_tvalid), $past(v3_r), "result appeared without a source item")
  // an accepted pair always lands in the first stage
  `GDD_ASSERT_NEXT(a_accept_v1, in_tvalid && in_tready, v1_r, "accepted pair lost at stage one")

endmodule

// ===== src/gdd_day_number.sv =====
module gdd_day_number (
  input  logic                         clk,
  input  gdd_pkg::gdd_en_t             en,
  input  logic [gdd_pkg::DAY_W-1:0]    day,
  input  logic [gdd_pkg::MONTH_W-1:0]  month,
  input  logic [gdd_pkg::YEAR_W-1:0]   year,
  output logic [gdd_pkg::DN_W-1:0]     day_num
);
  import gdd_pkg::*;

  // stage 1: clamp, p = year - 1, p / 100
  logic [YEAR_W-1:0]           year_c;
  logic [MONTH_W-1:0]          month_c;
  logic [YEAR_W+RECIP_W-1:0]   prod;
  logic [YEAR_W-1:0]           p_nxt, p_r;
  logic [Q100_W-1:0]           q100_nxt, q100_r;
  logic [MONTH_W-1:0]          m_r;
  logic [DAY_W-1:0]            d_r;

  always_comb begin
    if (year == '0) begin
      year_c = YEAR_W'(1);
    end else if (32'(year) > MAX_YEAR) begin
      year_c = YEAR_W'(MAX_YEAR);
    end else begin
      year_c = year;
    end
    if (month == '0) begin
      month_c = MONTH_JAN;
    end else if (month inside {[4'd13:4'd15]}) begin
      month_c = MONTH_DEC;
    end else begin
      month_c = month;
    end
    p_nxt    = year_c - YEAR_W'(1);
    prod     = (YEAR_W+RECIP_W)'(p_nxt) * (YEAR_W+RECIP_W)'(RECIP_100);
    q100_nxt = prod[RECIP_SHIFT +: Q100_W];
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      p_r    <= p_nxt;
      q100_r <= q100_nxt;
      m_r    <= month_c;
      d_r    <= day;
    end
  end

  // stage 2: whole-year days, leap flag and day of year
  logic [DN_W-1:0]   yd_nxt, yd_r;
  logic [YEAR_W-1:0] hund;
  logic [REM_W-1:0]  rem;
  logic              leap;
  logic [8:0]        mo_nxt, mo_r;

  always_comb begin
    yd_nxt = DN_W'(p_r) * DN_W'(DAYS_PER_YEAR) + DN_W'(p_r >> 2)
             - DN_W'(q100_r) + DN_W'(q100_r >> 2);
    hund   = YEAR_W'(q100_r) * YEAR_W'(CENTURY);
    rem    = REM_W'(p_r - hund);
    // year = p + 1: divisible by 4 when p ends in 3, a century when p % 100 is 99
    leap   = (p_r[1:0] == 2'd3) && ((rem != CENTURY_LAST) || (q100_r[1:0] == 2'd3));
    // day minus one is left out: it cancels in the difference
    mo_nxt = month_start(m_r) + 9'(leap && (m_r > MONTH_FEB)) + 9'(d_r);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      yd_r <= yd_nxt;
      mo_r <= mo_nxt;
    end
  end

  // stage 3: sum
  logic [DN_W-1:0] dn_r;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      dn_r <= yd_r + DN_W'(mo_r);
    end
  end

  assign day_num = dn_r;

endmodule

// ===== src/gdd_diff.sv =====
module gdd_diff (
  input  logic                        clk,
  input  logic                        en,
  input  logic [gdd_pkg::DN_W-1:0]    first_num,
  input  logic [gdd_pkg::DN_W-1:0]    second_num,
  output logic signed [gdd_pkg::DIFF_W-1:0] day_difference
);
  import gdd_pkg::*;

  logic signed [DN_W:0]       diff;
  logic signed [DIFF_W-1:0]   diff_nxt, diff_r;

  always_comb begin
    diff = $signed({1'b0, second_num}) - $signed({1'b0, first_num});
    if (diff > (DN_W+1)'(DIFF_MAX)) begin
      diff_nxt = DIFF_W'(DIFF_MAX);
    end else if (diff < (DN_W+1)'(DIFF_MIN)) begin
      diff_nxt = DIFF_W'(DIFF_MIN);
    end else begin
      diff_nxt = DIFF_W'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= diff_nxt;
    end
  end

  assign day_difference = diff_r;

endmodule

// ===== tb/date_diff_checker.sv =====
`timescale 1ns / 1ps

module date_diff_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [gdd_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [gdd_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             error_count,
  output int                             diffs_pending
);
  import gdd_pkg::*;

  // cumulative days before each month, common year
  localparam int DAYS_BEFORE[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  logic [DIFF_W-1:0] diff_q[$];

  function automatic int day_index(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                                   input logic [YEAR_W-1:0] y);
    int yr;
    int mo;
    int p;
    int n;
    yr = y;
    mo = m;
    if (yr < 1) yr = 1;
    if (yr > int'(MAX_YEAR)) yr = MAX_YEAR;
    if (mo < 1) mo = 1;
    if (mo > 12) mo = 12;
    p = yr - 1;
    n = p * 365 + p / 4 - p / 100 + p / 400 + DAYS_BEFORE[mo - 1];
    if (mo > 2 && ((yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0)))) n++;
    return n + int'(d) - 1;
  endfunction

  function automatic logic [DIFF_W-1:0] days_between(input logic [IN_DATA_W-1:0] w);
    int delta;
    delta = day_index(w[27:23], w[31:28], w[45:32]) - day_index(w[4:0], w[8:5], w[22:9]);
    if (delta > DIFF_MAX) delta = DIFF_MAX;
    if (delta < DIFF_MIN) delta = DIFF_MIN;
    return delta[DIFF_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [DIFF_W-1:0] want;
    logic [DIFF_W-1:0] got;
    if (!rst_n) begin
      error_count   <= 0;
      diffs_pending <= 0;
    end else begin
      if (in_tvalid && in_tready) diff_q.push_back(days_between(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[DIFF_W-1:0];
        if (diff_q.size() == 0) begin
          $error("day_difference: no transfer expected, got %0d", $signed(got));
          error_count <= error_count + 1;
        end else begin
          want = diff_q.pop_front();
          if (got !== want) begin
            $error("day_difference: expected %0d, got %0d", $signed(want), $signed(got));
            error_count <= error_count + 1;
          end
        end
      end
      diffs_pending <= diff_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import gdd_pkg::*;

  localparam int RANDOM_PAIRS = 650;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int   error_count;
  int   diffs_pending;
  int   burst_left = 0;
  int   cycle_count = 0;
  int   rx_cycle = 0;
  int   hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  gregorian_date_difference u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  date_diff_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .error_count  (error_count),
    .diffs_pending(diffs_pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: one long hold-off on request, otherwise a rotating stall mix
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 97) % 4)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 1) == 1);
        2:       out_tready <= ($urandom_range(0, 4) != 0);
        default: out_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  function automatic int month_length(input int m, input int y);
    if (m == 2) return ((y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0))) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  task automatic send_pair(input int d1, input int m1, input int y1,
                           input int d2, input int m2, input int y2);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, y2[YEAR_W-1:0], m2[MONTH_W-1:0], d2[DAY_W-1:0],
                  y1[YEAR_W-1:0], m1[MONTH_W-1:0], d1[DAY_W-1:0]};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random_pair();
    int kind;
    int d1, m1, y1, d2, m2, y2;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      // raw field noise: out-of-range years, months and days
      send_pair($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383),
                $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383));
    end else begin
      y1 = $urandom_range(1, MAX_YEAR);
      if (kind < 55) begin
        y2 = y1 + $urandom_range(0, 6) - 3;
        if (y2 < 1) y2 = 1;
        if (y2 > int'(MAX_YEAR)) y2 = MAX_YEAR;
      end else begin
        y2 = $urandom_range(1, MAX_YEAR);
      end
      m1 = $urandom_range(1, 12);
      m2 = $urandom_range(1, 12);
      d1 = $urandom_range(1, month_length(m1, y1));
      d2 = $urandom_range(1, month_length(m2, y2));
      send_pair(d1, m1, y1, d2, m2, y2);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pair(1, 1, 1, 31, 12, 9999);
    send_pair(31, 12, 9999, 1, 1, 1);
    send_pair(15, 6, 1987, 15, 6, 1987);
    send_pair(28, 2, 2000, 1, 3, 2000);
    send_pair(28, 2, 1900, 1, 3, 1900);
    send_pair(28, 2, 2004, 1, 3, 2004);
    send_pair(28, 2, 2001, 1, 3, 2001);
    send_pair(1, 1, 0, 1, 1, 1);
    send_pair(31, 12, 16383, 1, 1, 10000);
    send_pair(15, 0, 2020, 15, 1, 2020);
    send_pair(15, 15, 2020, 15, 13, 2021);
    send_pair(0, 3, 2024, 29, 2, 2024);
    send_pair(31, 2, 2023, 3, 3, 2023);
    send_pair(31, 4, 2023, 1, 5, 2023);
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(31, 15, 16383, 31, 15, 16383);
    send_pair(31, 12, 1999, 1, 1, 2000);
    send_pair(1, 1, 2000, 31, 12, 2000);
    send_pair(10, 10, 10922, 21, 5, 5461);

    // receiver holds off while the pairs keep coming
    hold_req <= 1'b1;
    repeat (RANDOM_PAIRS) send_random_pair();
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (diffs_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (error_count == 0 && diffs_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
